[sv/rds_pkg.sv]
package rds_pkg;

    localparam int FRAC   = 16;
    localparam int CFG_W  = 18;
    localparam int POS_W  = 24;
    localparam int DIR_W  = 19;
    localparam int DIST_W = 32;
    localparam int QUO_W  = 33;
    localparam int DIV_N  = 33;

    typedef enum logic [2:0] {
        REG_CAM_DIR_X = 3'd0,
        REG_CAM_DIR_Y = 3'd1,
        REG_PLANE_X   = 3'd2,
        REG_PLANE_Y   = 3'd3,
        REG_POS_X     = 3'd4,
        REG_POS_Y     = 3'd5
    } t_reg_idx;

    // one axis of a ray on its way through the reciprocal divider
    typedef struct packed {
        logic signed [DIR_W-1:0] dir;
        logic                    neg;
        logic [DIR_W-1:0]        mag;
        logic [FRAC:0]           gap;
        logic [7:0]              tile;
        logic [DIR_W-1:0]        rem;
        logic [QUO_W-1:0]        quo;
    } t_lane;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir;
        logic                    neg;
        logic [FRAC:0]           gap;
        logic [7:0]              tile;
        logic                    sat;
        logic [DIST_W-1:0]       delta;
        logic [FRAC+DIST_W:0]    prod;
    } t_mlane;

endpackage

[sv/ray_dda_setup.sv]
// Ray setup for grid DDA raycasting, one screen column per beat.
// Slave stream: o_s_axis_tready / i_s_axis_tvalid / i_s_axis_tdata carry the column.
// Master stream: one result beat per column, in order, with ray direction, map cell,
// step signs, delta and side distances (Q16.16, saturated).
// APB port: camera direction, camera plane and player position at byte address 4*i;
// write them only while no column is in flight.
// Throughput: one column per cycle; the reciprocal |1/dir| runs through a 33-stage
// restoring divider (one quotient bit per stage), so the depth is set by that unit.
// Stall: all stages advance together; while the result beat is held and
// i_m_axis_tready is low the whole pipe holds and o_s_axis_tready drops.
// Reset (synchronous, active low) clears all valid bits and loads the default camera.
module ray_dda_setup
    import rds_pkg::*;
#(
    parameter int SCREEN_WIDTH = 640
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [15:0]  i_s_axis_tdata,   // [9:0] column
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [18:0] dir_x, [37:19] dir_y, [45:38] cell_x, [53:46] cell_y, [54] step_neg_x,
    // [55] step_neg_y, [87:56] delta_x, [119:88] delta_y, [151:120] side_x,
    // [183:152] side_y
    output logic [183:0] o_m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int          COL_W   = 10;
    localparam int          SW_W    = 13;
    localparam logic [28:0] RECIP   = 29'((64'd1 << 28) / SCREEN_WIDTH);
    localparam logic [SW_W-1:0] SW  = SW_W'(SCREEN_WIDTH);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(SCREEN_WIDTH - 1);

    // configuration
    logic signed [CFG_W-1:0] r_cam [2];
    logic signed [CFG_W-1:0] r_pln [2];
    logic [POS_W-1:0]        r_pos [2];
    t_reg_idx                wr_idx;

    assign pready = 1'b1;
    assign wr_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam[0] <= 18'sd65536;
            r_cam[1] <= '0;
            r_pln[0] <= '0;
            r_pln[1] <= 18'sd43254;
            r_pos[0] <= 24'd98304;
            r_pos[1] <= 24'd98304;
        end else if (psel && penable && pwrite && pready) begin
            unique case (wr_idx)
                REG_CAM_DIR_X: r_cam[0] <= pwdata[CFG_W-1:0];
                REG_CAM_DIR_Y: r_cam[1] <= pwdata[CFG_W-1:0];
                REG_PLANE_X:   r_pln[0] <= pwdata[CFG_W-1:0];
                REG_PLANE_Y:   r_pln[1] <= pwdata[CFG_W-1:0];
                REG_POS_X:     r_pos[0] <= pwdata[POS_W-1:0];
                REG_POS_Y:     r_pos[1] <= pwdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (wr_idx)
            REG_CAM_DIR_X: prdata = 32'(r_cam[0]);
            REG_CAM_DIR_Y: prdata = 32'(r_cam[1]);
            REG_PLANE_X:   prdata = 32'(r_pln[0]);
            REG_PLANE_Y:   prdata = 32'(r_pln[1]);
            REG_POS_X:     prdata = {8'd0, r_pos[0]};
            REG_POS_Y:     prdata = {8'd0, r_pos[1]};
            default:       prdata = '0;
        endcase
    end

    // pipeline control: every stage moves on the same enable
    logic en;
    logic r_v1, r_v2, r_v3, r_v4, r_vm, r_vo;
    logic [DIV_N:0] r_vd;

    assign en              = !r_vo || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vd <= '0;
            r_vm <= 1'b0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_vd <= {r_vd[DIV_N-1:0], r_v4};
            r_vm <= r_vd[DIV_N];
            r_vo <= r_vm;
        end
    end

    // column factor: floor(col * 2^17 / W) - 2^16 via reciprocal and one correction
    logic [COL_W-1:0]        col_c;
    logic [COL_W-1:0]        r1_col, r2_col;
    logic [COL_W+28:0]       r1_prod;
    logic [FRAC+1:0]         q0;
    logic [FRAC+1:0]         r2_q0;
    logic [27:0]             r2_qw;
    logic [27:0]             rem3;
    logic signed [FRAC+1:0]  r3_u;
    logic signed [35:0]      r4_pr [2];

    assign col_c = ({22'd0, i_s_axis_tdata[COL_W-1:0]} >= 32'(SCREEN_WIDTH))
                   ? COL_LAST : i_s_axis_tdata[COL_W-1:0];
    assign q0    = r1_prod[28:11];
    assign rem3  = {1'b0, r2_col, 17'd0} - r2_qw;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_col  <= col_c;
            r1_prod <= 39'(col_c * RECIP);
            r2_col  <= r1_col;
            r2_q0   <= q0;
            r2_qw   <= 28'(q0 * SW);
            r3_u    <= $signed(r2_q0 + {17'd0, (rem3 >= {15'd0, SW})} - 18'h10000);
            r4_pr[0] <= r_pln[0] * r3_u;
            r4_pr[1] <= r_pln[1] * r3_u;
        end
    end

    // direction, step sign, grid gap; then the divider
    t_lane [1:0] r_dv [DIV_N+1];

    for (genvar a = 0; a < 2; a++) begin : g_axis
        logic signed [DIR_W:0]   sum;
        logic signed [DIR_W-1:0] dir;
        logic [FRAC-1:0]         frac;

        assign sum  = {{2{r_cam[a][CFG_W-1]}}, r_cam[a]} + r4_pr[a][35:FRAC];
        assign dir  = sum[DIR_W-1:0];
        assign frac = r_pos[a][FRAC-1:0];

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[0][a].dir  <= dir;
                r_dv[0][a].neg  <= dir[DIR_W-1];
                r_dv[0][a].mag  <= dir[DIR_W-1] ? DIR_W'(-dir) : dir;
                r_dv[0][a].gap  <= dir[DIR_W-1] ? {1'b0, frac}
                                                : (17'h10000 - {1'b0, frac});
                r_dv[0][a].tile <= r_pos[a][POS_W-1:FRAC];
                r_dv[0][a].rem  <= '0;
                r_dv[0][a].quo  <= '0;
            end
        end

        // one quotient bit of 2^32 / mag per stage
        for (genvar k = 0; k < DIV_N; k++) begin : g_div
            logic [DIR_W-1:0] sh;
            logic             ge;

            assign sh = {r_dv[k][a].rem[DIR_W-2:0], (k == 0) ? 1'b1 : 1'b0};
            assign ge = sh >= r_dv[k][a].mag;

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv[k+1][a].dir  <= r_dv[k][a].dir;
                    r_dv[k+1][a].neg  <= r_dv[k][a].neg;
                    r_dv[k+1][a].mag  <= r_dv[k][a].mag;
                    r_dv[k+1][a].gap  <= r_dv[k][a].gap;
                    r_dv[k+1][a].tile <= r_dv[k][a].tile;
                    r_dv[k+1][a].rem  <= ge ? sh - r_dv[k][a].mag : sh;
                    r_dv[k+1][a].quo  <= {r_dv[k][a].quo[QUO_W-2:0], ge};
                end
            end
        end

        // saturate delta and scale by the grid gap
        t_lane                   last;
        logic                    sat;
        logic [DIST_W-1:0]       delta;
        t_mlane                  r_m;
        logic [DIST_W-1:0]       side;

        assign last  = r_dv[DIV_N][a];
        assign sat   = (last.mag == '0) || last.quo[QUO_W-1];
        assign delta = sat ? '1 : last.quo[DIST_W-1:0];

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_m.dir   <= last.dir;
                r_m.neg   <= last.neg;
                r_m.gap   <= last.gap;
                r_m.tile  <= last.tile;
                r_m.sat   <= sat;
                r_m.delta <= delta;
                r_m.prod  <= last.gap * delta;
            end
        end

        always_comb begin
            if (r_m.gap == '0) begin
                side = '0;
            end else if (r_m.sat || r_m.prod[FRAC+DIST_W]) begin
                side = '1;
            end else begin
                side = r_m.prod[FRAC+DIST_W-1:FRAC];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                o_m_axis_tdata[a*DIR_W +: DIR_W]        <= r_m.dir;
                o_m_axis_tdata[38 + a*8 +: 8]           <= r_m.tile;
                o_m_axis_tdata[54 + a]                  <= r_m.neg;
                o_m_axis_tdata[56 + a*DIST_W +: DIST_W] <= r_m.delta;
                o_m_axis_tdata[120 + a*DIST_W +: DIST_W] <= side;
            end
        end
    end

    a_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not follow output stall");

    a_sign_x : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[54] == o_m_axis_tdata[18]))
        else $error("step_neg_x disagrees with dir_x sign");

    a_sign_y : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[55] == o_m_axis_tdata[37]))
        else $error("step_neg_y disagrees with dir_y sign");

    a_flow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vm && !en) |=> r_vm)
        else $error("stage dropped a beat while stalled");

endmodule

[test/tb.sv]
module tb
    import rds_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH      = 640;
    localparam int DRAIN      = 60;
    localparam int WATCH_MAX  = 20000;
    localparam logic [31:0] DMAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0]        side_y;
        logic [31:0]        side_x;
        logic [31:0]        delta_y;
        logic [31:0]        delta_x;
        logic               step_neg_y;
        logic               step_neg_x;
        logic [7:0]         cell_y;
        logic [7:0]         cell_x;
        logic [DIR_W-1:0]   dir_y;
        logic [DIR_W-1:0]   dir_x;
    } t_ray;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [15:0]  i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [183:0] o_m_axis_tdata;
    logic         psel, penable, pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    ray_dda_setup #(.SCREEN_WIDTH(WIDTH)) dut (.*);

    // shadow registers
    logic signed [CFG_W-1:0] sh_cam_x, sh_cam_y, sh_pln_x, sh_pln_y;
    logic [POS_W-1:0]        sh_pos_x, sh_pos_y;

    logic [15:0] column_q[$];
    t_ray        ray_q[$];
    int          send_idle_pct, stall_pct;
    bit          hold_send;
    int          errors, quiet_cycles;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void ray_axis(input longint d, input logic [POS_W-1:0] pos,
                                     output logic [31:0] delta, output logic [31:0] side,
                                     output logic neg);
        longint unsigned one, frac, mag, q, gap, s;
        bit sat;
        one  = 64'd1 << FRAC;
        frac = pos & (one - 1);
        neg  = d < 0;
        mag  = neg ? -d : d;
        sat  = 0;
        if (mag == 0) begin
            q = DMAX;
            sat = 1;
        end else begin
            q = (64'd1 << (2 * FRAC)) / mag;
            if (q > DMAX) begin
                q = DMAX;
                sat = 1;
            end
        end
        gap = neg ? frac : one - frac;
        if (gap == 0) s = 0;
        else if (sat) s = DMAX;
        else begin
            s = (gap * q) >> FRAC;
            if (s > DMAX) s = DMAX;
        end
        delta = q[31:0];
        side  = s[31:0];
    endfunction

    function automatic longint floor_frac(input longint p);
        return p >>> FRAC;
    endfunction

    function automatic t_ray cast_ray(input logic [9:0] col_in);
        t_ray r;
        longint col, u, dx, dy;
        col = col_in;
        if (col >= WIDTH) col = WIDTH - 1;
        u  = ((2 * col) << FRAC) / WIDTH - (64'sd1 << FRAC);
        dx = longint'(sh_cam_x) + floor_frac(longint'(sh_pln_x) * u);
        dy = longint'(sh_cam_y) + floor_frac(longint'(sh_pln_y) * u);
        r.dir_x  = dx[DIR_W-1:0];
        r.dir_y  = dy[DIR_W-1:0];
        r.cell_x = sh_pos_x[FRAC+7:FRAC];
        r.cell_y = sh_pos_y[FRAC+7:FRAC];
        ray_axis(dx, sh_pos_x, r.delta_x, r.side_x, r.step_neg_x);
        ray_axis(dy, sh_pos_y, r.delta_y, r.side_y, r.step_neg_y);
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (i_s_axis_tvalid) begin
                ray_q.push_back(cast_ray(i_s_axis_tdata[9:0]));
                void'(column_q.pop_front());
            end
            if (column_q.size() > 0) begin
                if (!hold_send && $urandom_range(99) >= send_idle_pct) begin
                    i_s_axis_tvalid <= 1;
                    i_s_axis_tdata  <= column_q[0];
                end else begin
                    i_s_axis_tvalid <= 0;
                end
            end else begin
                i_s_axis_tvalid <= 0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_ray got, want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_ray'(o_m_axis_tdata);
                if (ray_q.size() == 0) begin
                    $display("%0t unexpected ray beat %h", $realtime, got);
                    errors++;
                end else begin
                    want = ray_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (got.dir_x !== want.dir_x)
                            $display("%0t dir_x exp %h got %h", $realtime, want.dir_x, got.dir_x);
                        if (got.dir_y !== want.dir_y)
                            $display("%0t dir_y exp %h got %h", $realtime, want.dir_y, got.dir_y);
                        if (got.cell_x !== want.cell_x)
                            $display("%0t cell_x exp %h got %h", $realtime, want.cell_x,
                                     got.cell_x);
                        if (got.cell_y !== want.cell_y)
                            $display("%0t cell_y exp %h got %h", $realtime, want.cell_y,
                                     got.cell_y);
                        if (got.step_neg_x !== want.step_neg_x)
                            $display("%0t step_neg_x exp %b got %b", $realtime,
                                     want.step_neg_x, got.step_neg_x);
                        if (got.step_neg_y !== want.step_neg_y)
                            $display("%0t step_neg_y exp %b got %b", $realtime,
                                     want.step_neg_y, got.step_neg_y);
                        if (got.delta_x !== want.delta_x)
                            $display("%0t delta_x exp %h got %h", $realtime, want.delta_x,
                                     got.delta_x);
                        if (got.delta_y !== want.delta_y)
                            $display("%0t delta_y exp %h got %h", $realtime, want.delta_y,
                                     got.delta_y);
                        if (got.side_x !== want.side_x)
                            $display("%0t side_x exp %h got %h", $realtime, want.side_x,
                                     got.side_x);
                        if (got.side_y !== want.side_y)
                            $display("%0t side_y exp %h got %h", $realtime, want.side_y,
                                     got.side_y);
                    end
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (column_q.size() == 0 && ray_q.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCH_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1;
        pwrite  <= 1;
        paddr   <= 5'(idx) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        case (idx)
            REG_CAM_DIR_X: sh_cam_x = val[CFG_W-1:0];
            REG_CAM_DIR_Y: sh_cam_y = val[CFG_W-1:0];
            REG_PLANE_X:   sh_pln_x = val[CFG_W-1:0];
            REG_PLANE_Y:   sh_pln_y = val[CFG_W-1:0];
            REG_POS_X:     sh_pos_x = val[POS_W-1:0];
            REG_POS_Y:     sh_pos_y = val[POS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (column_q.size() != 0 || i_s_axis_tvalid || ray_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic load_camera(input logic [31:0] cx, cy, px, py, ppx, ppy);
        write_reg(REG_CAM_DIR_X, cx);
        write_reg(REG_CAM_DIR_Y, cy);
        write_reg(REG_PLANE_X, px);
        write_reg(REG_PLANE_Y, py);
        write_reg(REG_POS_X, ppx);
        write_reg(REG_POS_Y, ppy);
    endtask

    function automatic logic [31:0] rand_dir(input int mode);
        case (mode)
            0: return 32'($urandom_range(0, 3)) - 32'd1;                 // near zero
            1: return $urandom_range(0, 1) ? 32'h1FFFF : 32'h20000;      // extremes
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int ph, n;
        logic [31:0] v[6];
        i_rst_n = 0;
        i_s_axis_tvalid = 0;
        i_s_axis_tdata = 0;
        i_m_axis_tready = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        errors = 0; quiet_cycles = 0; hold_send = 0;
        send_idle_pct = 0; stall_pct = 0;
        sh_cam_x = 65536; sh_cam_y = 0; sh_pln_x = 0; sh_pln_y = 43254;
        sh_pos_x = 98304; sh_pos_y = 98304;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset camera, edge columns and out-of-range columns
        foreach (v[k]) v[k] = 0;
        column_q = '{16'd0, 16'd1, 16'd319, 16'd320, 16'd639, 16'd640, 16'd1023, 16'hFFFF};
        drain();
        // zero direction on both axes, integer x position and non-integer y position
        load_camera(0, 0, 0, 0, 32'h050000, 32'hFFFFFF);
        column_q = '{16'd0, 16'd320, 16'd639};
        drain();
        // tiny and extreme directions
        load_camera(32'h1, 32'h3FFFF, 32'h1FFFF, 32'h20000, 32'h000000, 32'hFFFFFF);
        column_q = '{16'd0, 16'd160, 16'd320, 16'd480, 16'd639, 16'd700};
        drain();
        load_camera(32'h20000, 32'h1FFFF, 32'h20000, 32'h1FFFF, 32'h010000, 32'h00FFFF);
        column_q = '{16'd0, 16'd1, 16'd638, 16'd639};
        drain();

        for (ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 45; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 45; end
                default: begin send_idle_pct = 20; stall_pct = 20; end
            endcase
            for (int k = 0; k < 4; k++) v[k] = rand_dir($urandom_range(0, 5));
            load_camera(v[0], v[1], v[2], v[3],
                        $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 255)) << FRAC
                                                  : $urandom,
                        $urandom_range(0, 3) == 0 ? 32'hFFFFFF : $urandom);
            n = 100;
            for (int k = 0; k < n; k++)
                column_q.push_back($urandom_range(0, 7) == 0 ? 16'($urandom)
                                                             : 16'($urandom_range(0, 639)));
            if (ph == 5) begin
                // pause the sender until the pipe is empty, then resume
                while (column_q.size() > n / 2) @(posedge i_clk);
                hold_send = 1;
                while (i_s_axis_tvalid || ray_q.size() != 0) @(posedge i_clk);
                hold_send = 0;
            end
            drain();
        end

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
